@@ hw/rtl/aarm_pkg.sv @@
// ----------------------------------------------------------------------------
// aarm_pkg: shared constants for the axis-angle rotation matrix block
// Holds the default fraction width and the quarter-sine polynomial terms.
// ----------------------------------------------------------------------------
package aarm_pkg;

  // Default number of fraction bits for axis, sine, cosine and entries.
  localparam int unsigned FRACTION_BITS_DEF = 14;

  // Width of a Q30 value in [0, 1] held unsigned.
  localparam int unsigned Q30_W = 31;

  // Number of Horner steps after the leading coefficient.
  localparam int unsigned HORNER_STEPS = 5;

  // Coefficients (pi/2)^k / k! for odd k, Q30, index 0 is k = 1.
  function automatic logic [Q30_W-1:0] sin_coef(input logic [2:0] idx);
    logic [Q30_W-1:0] val;
    begin
      case (idx)
        3'd0:    val = 31'd1686629713;
        3'd1:    val = 31'd693598666;
        3'd2:    val = 31'd85569306;
        3'd3:    val = 31'd5026995;
        3'd4:    val = 31'd172272;
        3'd5:    val = 31'd3864;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

endpackage

@@ hw/rtl/axis_angle_rotation_matrix.sv @@
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register waits for the downstream side.
// Reset: rst_ni clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: 3x3 rotation matrix from axis and angle
// Polynomial sine and cosine, then the Rodrigues formula with saturation.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
  parameter int unsigned FRACTION_BITS = aarm_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle [63:48]
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each from bit 0 up
  output logic [143:0] m_axis_tdata
);
  import aarm_pkg::*;

  localparam int unsigned F      = FRACTION_BITS;
  localparam int unsigned NST    = 12;
  localparam int unsigned SHN    = 30 - F;
  localparam int unsigned SW     = F + 2;          // sine and cosine
  localparam int unsigned TW     = F + 3;          // t = one - c
  localparam int unsigned TXW    = TW + 16;        // t * axis
  localparam int unsigned TXXW   = TW + 32;        // t * axis * axis
  localparam int unsigned XSW    = SW + 16;        // axis * s
  localparam int unsigned RW     = 34;             // rounded triple product
  localparam int unsigned PW     = 18;             // rounded axis * s
  localparam int unsigned EW     = 35;             // entry before saturation
  localparam logic signed [32:0]     RND_S  = (SHN > 0) ? (33'sd1 <<< (SHN - 1)) : 33'sd0;
  localparam logic signed [XSW:0]    RND_P  = (XSW + 1)'(1) << (F - 1);
  localparam logic signed [TXXW:0]   RND_T  = (TXXW + 1)'(1) << (2 * F - 1);
  localparam logic signed [TW-1:0]   ONE_T  = TW'(1) << F;
  localparam logic signed [EW-1:0]   ONE_E  = EW'(1) << F;
  localparam logic [Q30_W-1:0]       Q30_ONE = Q30_W'(1) << 30;

  // Saturate to plus or minus one and keep the low 16 bits.
  function automatic logic [15:0] sat_entry(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    begin
      r = v;
      if (v > ONE_E) r = ONE_E;
      if (v < -ONE_E) r = -ONE_E;
      return r[15:0];
    end
  endfunction

  logic en;
  logic vld_q [NST];

  // Carried input fields.
  logic signed [15:0] ax_q [10];
  logic signed [15:0] ay_q [10];
  logic signed [15:0] az_q [10];
  logic [1:0]         quad_q [8];

  // Polynomial arguments, their squares and the Horner partial sums.
  logic [Q30_W-1:0] u_q  [7];
  logic [Q30_W-1:0] v_q  [7];
  logic [Q30_W-1:0] u2_q [HORNER_STEPS];
  logic [Q30_W-1:0] v2_q [HORNER_STEPS];
  logic [Q30_W-1:0] ps_q [HORNER_STEPS];
  logic [Q30_W-1:0] pc_q [HORNER_STEPS];
  logic [Q30_W-1:0] ps_d [HORNER_STEPS];
  logic [Q30_W-1:0] pc_d [HORNER_STEPS];
  logic [Q30_W-1:0] sr_q, cr_q;

  // Trigonometric values and products.
  logic signed [SW-1:0]  s_q, c8_q, c9_q, c10_q;
  logic signed [TW-1:0]  t_q;
  logic signed [TXW-1:0] tx_q, ty_q, tz_q;
  logic signed [PW-1:0]  xs9_q, ys9_q, zs9_q, xs_q, ys_q, zs_q;
  logic signed [RW-1:0]  txx_q, tyy_q, tzz_q, txy_q, txz_q, tyz_q;
  logic [143:0]          out_q;

  // Whole pipeline moves when the output register is free or being taken.
  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = out_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // One Horner step per stage for sine and cosine.
  always_comb begin
    logic [2*Q30_W-1:0] ms, mc;
    logic [Q30_W-1:0]   prs, prc;
    for (int j = 0; j < HORNER_STEPS; j++) begin
      prs = (j == 0) ? sin_coef(3'd5) : ps_q[(j == 0) ? 0 : j-1];
      prc = (j == 0) ? sin_coef(3'd5) : pc_q[(j == 0) ? 0 : j-1];
      ms = u2_q[j] * prs;
      mc = v2_q[j] * prc;
      ps_d[j] = sin_coef(3'(HORNER_STEPS - 1 - j)) - ms[30 +: Q30_W];
      pc_d[j] = sin_coef(3'(HORNER_STEPS - 1 - j)) - mc[30 +: Q30_W];
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    logic [2*Q30_W-1:0]    sq_u, sq_v, fs, fc;
    logic signed [32:0]    s30, c30, sr, cr;
    logic signed [SW-1:0]  sn, cn;
    logic signed [XSW:0]   pxs, pys, pzs;
    logic signed [TXXW:0]  pxx, pyy, pzz, pxy, pxz, pyz;
    if (en) begin
      // Stage 0: capture the word and form u and 1 - u.
      ax_q[0]   <= s_axis_tdata[15:0];
      ay_q[0]   <= s_axis_tdata[31:16];
      az_q[0]   <= s_axis_tdata[47:32];
      quad_q[0] <= s_axis_tdata[63:62];
      u_q[0]    <= {1'b0, s_axis_tdata[61:48], 16'd0};
      v_q[0]    <= Q30_ONE - {1'b0, s_axis_tdata[61:48], 16'd0};
      for (int i = 1; i < 10; i++) begin
        ax_q[i] <= ax_q[i-1];
        ay_q[i] <= ay_q[i-1];
        az_q[i] <= az_q[i-1];
      end
      for (int i = 1; i < 8; i++) quad_q[i] <= quad_q[i-1];
      for (int i = 1; i < 7; i++) begin
        u_q[i] <= u_q[i-1];
        v_q[i] <= v_q[i-1];
      end

      // Stage 1: squares of the arguments.
      sq_u = u_q[0] * u_q[0];
      sq_v = v_q[0] * v_q[0];
      u2_q[0] <= sq_u[30 +: Q30_W];
      v2_q[0] <= sq_v[30 +: Q30_W];
      for (int j = 1; j < HORNER_STEPS; j++) begin
        u2_q[j] <= u2_q[j-1];
        v2_q[j] <= v2_q[j-1];
      end

      // Stages 2 to 6: Horner steps.
      for (int j = 0; j < HORNER_STEPS; j++) begin
        ps_q[j] <= ps_d[j];
        pc_q[j] <= pc_d[j];
      end

      // Stage 7: final multiply by the argument.
      fs = u_q[6] * ps_q[HORNER_STEPS-1];
      fc = v_q[6] * pc_q[HORNER_STEPS-1];
      sr_q <= fs[30 +: Q30_W];
      cr_q <= fc[30 +: Q30_W];

      // Stage 8: quadrant fold, rounding and t.
      sr = 33'(signed'({2'b00, sr_q}));
      cr = 33'(signed'({2'b00, cr_q}));
      case (quad_q[7])
        2'd0:    begin s30 = sr;  c30 = cr;  end
        2'd1:    begin s30 = cr;  c30 = -sr; end
        2'd2:    begin s30 = -sr; c30 = -cr; end
        default: begin s30 = -cr; c30 = sr;  end
      endcase
      sn = SW'((s30 + RND_S) >>> SHN);
      cn = SW'((c30 + RND_S) >>> SHN);
      s_q  <= sn;
      c8_q <= cn;
      t_q  <= ONE_T - TW'(cn);

      // Stage 9: t times axis and rounded axis times s.
      tx_q <= TXW'(t_q * ax_q[8]);
      ty_q <= TXW'(t_q * ay_q[8]);
      tz_q <= TXW'(t_q * az_q[8]);
      pxs = (XSW + 1)'(ax_q[8] * s_q) + RND_P;
      pys = (XSW + 1)'(ay_q[8] * s_q) + RND_P;
      pzs = (XSW + 1)'(az_q[8] * s_q) + RND_P;
      xs9_q <= PW'(pxs >>> F);
      ys9_q <= PW'(pys >>> F);
      zs9_q <= PW'(pzs >>> F);
      c9_q  <= c8_q;

      // Stage 10: rounded triple products.
      pxx = (TXXW + 1)'(tx_q * ax_q[9]) + RND_T;
      pyy = (TXXW + 1)'(ty_q * ay_q[9]) + RND_T;
      pzz = (TXXW + 1)'(tz_q * az_q[9]) + RND_T;
      pxy = (TXXW + 1)'(tx_q * ay_q[9]) + RND_T;
      pxz = (TXXW + 1)'(tx_q * az_q[9]) + RND_T;
      pyz = (TXXW + 1)'(ty_q * az_q[9]) + RND_T;
      txx_q <= RW'(pxx >>> (2 * F));
      tyy_q <= RW'(pyy >>> (2 * F));
      tzz_q <= RW'(pzz >>> (2 * F));
      txy_q <= RW'(pxy >>> (2 * F));
      txz_q <= RW'(pxz >>> (2 * F));
      tyz_q <= RW'(pyz >>> (2 * F));
      xs_q  <= xs9_q;
      ys_q  <= ys9_q;
      zs_q  <= zs9_q;
      c10_q <= c9_q;

      // Stage 11: sums, saturation and the output register.
      out_q[15:0]    <= sat_entry(EW'(txx_q) + EW'(c10_q));
      out_q[31:16]   <= sat_entry(EW'(txy_q) - EW'(zs_q));
      out_q[47:32]   <= sat_entry(EW'(txz_q) + EW'(ys_q));
      out_q[63:48]   <= sat_entry(EW'(txy_q) + EW'(zs_q));
      out_q[79:64]   <= sat_entry(EW'(tyy_q) + EW'(c10_q));
      out_q[95:80]   <= sat_entry(EW'(tyz_q) - EW'(xs_q));
      out_q[111:96]  <= sat_entry(EW'(txz_q) - EW'(ys_q));
      out_q[127:112] <= sat_entry(EW'(tyz_q) + EW'(xs_q));
      out_q[143:128] <= sat_entry(EW'(tzz_q) + EW'(c10_q));
    end
  end

  // An accepted word always enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  // A stall keeps the output valid bit set and freezes the first stage valid bit.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> vld_q[NST-1] && vld_q[0] == $past(vld_q[0]))
    else $error("pipeline moved during a stall");

  // t stays within zero and two after the quadrant fold.
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (t_q >= 0) && (t_q <= (ONE_T <<< 1)))
    else $error("t out of range");

  // The cosine term never exceeds one in magnitude.
  a_c_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[9] |-> (TW'(c9_q) <= ONE_T) && (TW'(c9_q) >= -ONE_T))
    else $error("cosine out of range");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for the axis-angle rotation matrix block
// Drives axis and angle words with random gaps, predicts each 3x3 matrix
// in fixed point and compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Holds the matrices that are still due and checks each arriving word.
class matrix_board;
  logic [143:0] due_q[$];
  int unsigned  errors;

  // Notes an accepted input word by queueing its predicted matrix.
  function void note_input(logic [143:0] mat);
    due_q.push_back(mat);
  endfunction

  // Compares a result word with the oldest predicted matrix.
  function void check_result(logic [143:0] got);
    logic [143:0] want;
    if (due_q.size() == 0) begin
      report_error($sformatf("result with none due: %h", got));
      return;
    end
    want = due_q.pop_front();
    for (int i = 0; i < 9; i++) begin
      if (got[16*i +: 16] !== want[16*i +: 16])
        report_error($sformatf("entry %0d got %h want %h", i, got[16*i +: 16],
                               want[16*i +: 16]));
    end
  endfunction

  function void report_error(string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endfunction
endclass

module tb;
  localparam int FB = aarm_pkg::FRACTION_BITS_DEF;
  localparam int LATENCY = 12;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;

  matrix_board board = new();
  bit          sending_done = 1'b0;
  bit          hold_off = 1'b0;

  axis_angle_rotation_matrix uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Floor division by a power of two; arithmetic shift does exactly that.
  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_sh(longint v, int n);
    if (n == 0) return v;
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // sin(pi/2*u) with u in Q30, odd polynomial by Horner's rule.
  function automatic longint quarter_sin(longint u);
    longint u2, p;
    u2 = floor_sh(u * u, 30);
    p = 3864;
    p = 172272 - floor_sh(u2 * p, 30);
    p = 5026995 - floor_sh(u2 * p, 30);
    p = 85569306 - floor_sh(u2 * p, 30);
    p = 693598666 - floor_sh(u2 * p, 30);
    p = 1686629713 - floor_sh(u2 * p, 30);
    return floor_sh(u * p, 30);
  endfunction

  function automatic logic [15:0] clamp_entry(longint v);
    longint one;
    one = longint'(1) << FB;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[15:0];
  endfunction

  // Predicts the rotation matrix for one axis and angle word.
  function automatic logic [143:0] rotation_of(logic [63:0] w);
    longint x, y, z, u, sn, cs, s30, c30, s, c, t;
    longint txx, tyy, tzz, txy, txz, tyz, xs, ys, zs;
    logic [143:0] m;
    x = longint'($signed(w[15:0]));
    y = longint'($signed(w[31:16]));
    z = longint'($signed(w[47:32]));
    u = longint'(w[61:48]) << 16;
    sn = quarter_sin(u);
    cs = quarter_sin((longint'(1) << 30) - u);
    case (w[63:62])
      2'd0: begin s30 = sn;  c30 = cs;  end
      2'd1: begin s30 = cs;  c30 = -sn; end
      2'd2: begin s30 = -sn; c30 = -cs; end
      default: begin s30 = -cs; c30 = sn; end
    endcase
    s = round_sh(s30, 30 - FB);
    c = round_sh(c30, 30 - FB);
    t = (longint'(1) << FB) - c;
    txx = round_sh(t * x * x, 2 * FB);
    tyy = round_sh(t * y * y, 2 * FB);
    tzz = round_sh(t * z * z, 2 * FB);
    txy = round_sh(t * x * y, 2 * FB);
    txz = round_sh(t * x * z, 2 * FB);
    tyz = round_sh(t * y * z, 2 * FB);
    xs = round_sh(x * s, FB);
    ys = round_sh(y * s, FB);
    zs = round_sh(z * s, FB);
    m[15:0]    = clamp_entry(txx + c);
    m[31:16]   = clamp_entry(txy - zs);
    m[47:32]   = clamp_entry(txz + ys);
    m[63:48]   = clamp_entry(txy + zs);
    m[79:64]   = clamp_entry(tyy + c);
    m[95:80]   = clamp_entry(tyz - xs);
    m[111:96]  = clamp_entry(txz - ys);
    m[127:112] = clamp_entry(tyz + xs);
    m[143:128] = clamp_entry(tzz + c);
    return m;
  endfunction

  // Sends one word, after a random gap when gaps is set, and waits until it is accepted.
  // The valid flag is only dropped when a gap follows, so that words can
  // follow each other without a bubble.
  task automatic send_word(logic [63:0] w, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(rotation_of(w));
  endtask

  // Random axis, mostly within unit length, sometimes a signed unit axis, sometimes raw noise.
  function automatic logic [63:0] random_word();
    logic [15:0] c[3];
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      for (int i = 0; i < 3; i++) c[i] = 16'($signed($urandom_range(0, 18918)) - 9459);
    end else if (pick < 8) begin
      c = '{16'h0, 16'h0, 16'h0};
      c[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    end else begin
      for (int i = 0; i < 3; i++) c[i] = 16'($urandom);
    end
    return {16'($urandom), c[2], c[1], c[0]};
  endfunction

  // Stimulus: directed corners, then random words.
  initial begin
    logic [15:0] angles[8];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF,
               16'h2000, 16'h0001};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (angles[i]) send_word({angles[i], 16'h0000, 16'h0000, 16'sd16384}, 1'b1);
    send_word({16'h1234, 16'h0000, 16'sd16384, 16'h0000}, 1'b0);
    send_word({16'h5555, -16'sd16384, 16'h0000, 16'h0000}, 1'b0);
    send_word({16'h9000, 16'h8000, 16'h8000, 16'h8000}, 1'b1);
    send_word({16'h6000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0);
    send_word({16'hA000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_word({16'h0000, 16'h8000, 16'h7FFF, 16'h1234}, 1'b1);
    send_word({16'hE38E, 16'sd9459, 16'sd9459, 16'sd9459}, 1'b1);
    // Burst without gaps while the receiver holds off, to fill the pipeline.
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send_word(random_word(), 1'b0);
    for (int i = 0; i < 1300; i++) send_word(random_word(), (i % 200) >= 40);
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off when asked.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
      end
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata);
    end
  end

  // End of run once all words are in and every matrix has arrived.
  initial begin
    wait (sending_done);
    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY * 4) @(posedge clk_i);
    if (board.errors == 0 && board.due_q.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
